// ===== rtl/uart3x_pkg.sv =====
package uart3x_pkg;

    // Width of the byte fields on the ports, whatever the frame length is.
    localparam int BYTE_W = 8;

    // Item kinds carried on s_tuser.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SEND = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUN,
        PH_STOP
    } phase_t;

    typedef struct packed {
        logic line;
        logic busy;
        logic refused;
    } tx_status_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              busy;
    } rx_status_t;

endpackage

// ===== rtl/uart3x_tx.sv =====
module uart3x_tx #(
    parameter int TICKS_PER_BIT = 3,
    parameter int DATA_BITS     = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         tick,
    input  logic                         send,
    input  logic [uart3x_pkg::BYTE_W-1:0] data,
    output uart3x_pkg::tx_status_t       status
);

    localparam int TW = $clog2(TICKS_PER_BIT + 1);
    localparam int BW = $clog2(DATA_BITS + 3);
    localparam int FW = DATA_BITS + 2;

    uart3x_pkg::phase_t phase_reg, phase_next;
    logic [TW-1:0]      tick_left_reg, tick_left_next;
    logic [BW-1:0]      bits_left_reg, bits_left_next;
    logic [FW-1:0]      frame_reg, frame_next;
    logic               level_reg, level_next;
    logic               refused;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= uart3x_pkg::PH_IDLE;
            tick_left_reg <= '0;
            bits_left_reg <= '0;
            frame_reg     <= '0;
            level_reg     <= 1'b1;
        end else begin
            phase_reg     <= phase_next;
            tick_left_reg <= tick_left_next;
            bits_left_reg <= bits_left_next;
            frame_reg     <= frame_next;
            level_reg     <= level_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        tick_left_next = tick_left_reg;
        bits_left_next = bits_left_reg;
        frame_next     = frame_reg;
        level_next     = level_reg;
        refused        = 1'b0;

        if (send) begin
            if (phase_reg != uart3x_pkg::PH_IDLE) begin
                refused = 1'b1;
            end else begin
                tick_left_next = TW'(1);
                bits_left_next = BW'(DATA_BITS + 2);
                frame_next     = {1'b1, data[DATA_BITS-1:0], 1'b0};
                phase_next     = uart3x_pkg::PH_RUN;
            end
        end else if (tick) begin
            if (phase_next == uart3x_pkg::PH_RUN) begin
                tick_left_next = tick_left_next - TW'(1);
                if (tick_left_next == '0) begin
                    level_next     = frame_next[0];
                    frame_next     = frame_next >> 1;
                    tick_left_next = TW'(TICKS_PER_BIT);
                    bits_left_next = bits_left_next - BW'(1);
                    if (bits_left_next == '0) begin
                        phase_next = uart3x_pkg::PH_STOP;
                    end
                end
            end
            // The stop hold counts the tick that put the stop bit out.
            if (phase_next == uart3x_pkg::PH_STOP) begin
                tick_left_next = tick_left_next - TW'(1);
                if (tick_left_next == '0) begin
                    phase_next = uart3x_pkg::PH_IDLE;
                end
            end
        end

        status.line    = level_next;
        status.busy    = (phase_next != uart3x_pkg::PH_IDLE);
        status.refused = refused;
    end

endmodule

// ===== rtl/uart3x_rx.sv =====
module uart3x_rx #(
    parameter int TICKS_PER_BIT = 3,
    parameter int DATA_BITS     = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   tick,
    input  logic                   line,
    output uart3x_pkg::rx_status_t status
);

    localparam int TW = $clog2(TICKS_PER_BIT + 2);
    localparam int BW = $clog2(DATA_BITS + 1);

    uart3x_pkg::phase_t   phase_reg, phase_next;
    logic [TW-1:0]        tick_left_reg, tick_left_next;
    logic [BW-1:0]        bits_left_reg, bits_left_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [DATA_BITS-1:0] byte_reg, byte_next;
    logic                 done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= uart3x_pkg::PH_IDLE;
            tick_left_reg <= '0;
            bits_left_reg <= '0;
            shift_reg     <= '0;
            byte_reg      <= '0;
        end else begin
            phase_reg     <= phase_next;
            tick_left_reg <= tick_left_next;
            bits_left_reg <= bits_left_next;
            shift_reg     <= shift_next;
            byte_reg      <= byte_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        tick_left_next = tick_left_reg;
        bits_left_next = bits_left_reg;
        shift_next     = shift_reg;
        byte_next      = byte_reg;
        done           = 1'b0;

        if (tick) begin
            if (phase_next == uart3x_pkg::PH_IDLE && !line) begin
                // Start edge: the first sample lands one tick into bit 0, which is the
                // middle of the bit at three ticks per bit.
                tick_left_next = TW'(TICKS_PER_BIT + 1);
                phase_next     = uart3x_pkg::PH_RUN;
                bits_left_next = BW'(DATA_BITS);
                shift_next     = '0;
            end else if (phase_next == uart3x_pkg::PH_RUN) begin
                tick_left_next = tick_left_next - TW'(1);
                if (tick_left_next == '0) begin
                    shift_next     = {line, shift_next[DATA_BITS-1:1]};
                    tick_left_next = TW'(TICKS_PER_BIT);
                    bits_left_next = bits_left_next - BW'(1);
                    if (bits_left_next == '0) begin
                        phase_next = uart3x_pkg::PH_STOP;
                        byte_next  = shift_next;
                        done       = 1'b1;
                    end
                end
            end
            if (phase_next == uart3x_pkg::PH_STOP) begin
                tick_left_next = tick_left_next - TW'(1);
                if (tick_left_next == '0) begin
                    phase_next = uart3x_pkg::PH_IDLE;
                end
            end
        end

        status.valid = done;
        status.data  = uart3x_pkg::BYTE_W'(byte_next);
        status.busy  = (phase_next != uart3x_pkg::PH_IDLE);
    end

endmodule

// ===== rtl/uart_8n1_triple_oversample_unit.sv =====
// UART transmitter and receiver driven by an oversampling tick stream. Each input item is
// either one tick (s_tuser low), which advances both halves and samples rx_line, or a send
// request (s_tuser high), which loads a frame of a start bit, DATA_BITS data bits LSB first
// and a stop bit; every bit lasts TICKS_PER_BIT ticks and the stop bit is held for a further
// TICKS_PER_BIT ticks including the one that drove it. A request made while the transmitter
// is busy is refused and flagged, and the byte is dropped. The receiver leaves idle on the
// first low sample, samples TICKS_PER_BIT+1 ticks later and then every TICKS_PER_BIT ticks,
// reports the byte with rx_valid on the completing tick and waits TICKS_PER_BIT ticks before
// it looks for a new start bit; the stop bit is not checked. Every item yields exactly one
// result item with the line levels and status after that item. The block takes one item
// per clock: the state update is a single pass of small counter and shift logic between the
// state registers and the output register, and an item is taken while a result still waits
// as long as that result is taken in the same cycle.
module uart_8n1_triple_oversample_unit #(
    parameter int TICKS_PER_BIT = 3,
    parameter int DATA_BITS     = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [7:0] tx_data, [8] rx_line, [15:9] zero
    input  logic        s_tuser,  // [0] kind: 0 tick, 1 send request
    // Result items.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // [0] tx_line, [1] tx_busy, [2] send_refused,
                                  // [3] rx_valid, [11:4] rx_data, [12] rx_busy, [15:13] zero
);

    logic                   in_accept;
    logic                   tick;
    logic                   send;
    uart3x_pkg::tx_status_t tx_status;
    uart3x_pkg::rx_status_t rx_status;
    logic                   out_valid_reg, out_valid_next;
    logic [15:0]            out_data_reg, out_data_next;

    // The output register frees up in the same cycle its item is taken downstream.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign tick      = in_accept && (s_tuser == uart3x_pkg::KIND_TICK);
    assign send      = in_accept && (s_tuser == uart3x_pkg::KIND_SEND);

    uart3x_tx #(
        .TICKS_PER_BIT (TICKS_PER_BIT),
        .DATA_BITS     (DATA_BITS)
    ) u_tx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .send    (send),
        .data    (s_tdata[7:0]),
        .status  (tx_status)
    );

    uart3x_rx #(
        .TICKS_PER_BIT (TICKS_PER_BIT),
        .DATA_BITS     (DATA_BITS)
    ) u_rx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick    (tick),
        .line    (s_tdata[8]),
        .status  (rx_status)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_accept) begin
            out_valid_next = 1'b1;
            out_data_next  = {3'b000, rx_status.busy, rx_status.data, rx_status.valid,
                              tx_status.refused, tx_status.busy, tx_status.line};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/uart3x_checker.sv =====
module uart3x_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A result that is not taken stays on offer unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Every accepted item produces a result in the next cycle.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result");

    // A refusal only happens while the transmitter is busy, and leaves it busy.
    a_refused_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("send refused while transmitter idle");

    // An idle transmitter holds the line high.
    a_idle_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[0])
        else $error("idle transmitter drives line low");

    // A completed byte is followed by the stop hold, so the receiver is still busy.
    a_rx_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[12])
        else $error("receiver idle on the completing tick");

endmodule

bind uart_8n1_triple_oversample_unit uart3x_checker u_uart3x_checker (.*);
